FILE: rtl/tsh_pkg.sv
// Shared types and constants for the transient shaper.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tsh_pkg;

  // Default sizes handed to the top level
  localparam int DELAY_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COEFF_W    = 16;
  localparam int DELAY_W    = 10;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FAST_COEFF     = 3'd0;
  localparam cfg_idx_t REG_SLOW_COEFF     = 3'd1;
  localparam cfg_idx_t REG_ATTACK_AMOUNT  = 3'd2;
  localparam cfg_idx_t REG_SUSTAIN_AMOUNT = 3'd3;
  localparam cfg_idx_t REG_DELAY_SAMPLES  = 3'd4;

  localparam logic [COEFF_W-1:0] FAST_COEFF_RST     = 16'd9830;
  localparam logic [COEFF_W-1:0] SLOW_COEFF_RST     = 16'd655;
  localparam logic [COEFF_W-1:0] ATTACK_AMOUNT_RST  = 16'd6144;
  localparam logic [COEFF_W-1:0] SUSTAIN_AMOUNT_RST = 16'd6144;
  localparam logic [DELAY_W-1:0] DELAY_SAMPLES_RST  = 10'd48;

  // Shared multiplier: signed A x signed B, registered product
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Envelope ratio, unsigned Q8.16
  localparam int RATIO_W = 24;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] ratio;
  } div_res_t;

endpackage

FILE: rtl/tsh_if.sv
// Handshake channels of the transient shaper: sample in, sample out, config write.
// Depends on tsh_pkg for the configuration widths.
`timescale 1ns / 1ps

interface tsh_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface tsh_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface tsh_cfg_if import tsh_pkg::*;;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tsh_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tsh_pkg for operand widths.
`timescale 1ns / 1ps

module tsh_mul import tsh_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0] prod
);

  // Register every product; the sequencer picks the cycle it needs
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: rtl/tsh_div.sv
// Iterative restoring divider for the envelope ratio (fast+1)*2^16/(slow+1),
// one quotient bit per cycle, saturated to RATIO_W bits. Depends on tsh_pkg.
`timescale 1ns / 1ps

module tsh_div import tsh_pkg::*; #(
  parameter int EW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [EW-1:0] fast_env,
  input  logic [EW-1:0] slow_env,
  output div_res_t      res
);

  typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN, DV_DONE} dv_state_t;

  localparam int CNT_W = $clog2(RATIO_W);

  dv_state_t          state;
  logic               finished;
  logic [EW:0]        num;
  logic [EW:0]        den;
  logic [EW:0]        rem;
  logic [RATIO_W-1:0] nlo;
  logic [RATIO_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;

  logic [EW+8:0]      den_sh;
  logic [EW:0]        trial;
  logic               fits;

  // Overflow test and one long-division step
  always_comb begin
    den_sh = {den, 8'h00};
    trial  = {rem[EW-1:0], nlo[RATIO_W-1]};
    fits   = (trial >= den);
  end

  // Sequence the division
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DV_IDLE;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            num   <= (EW+1)'(fast_env) + (EW+1)'(1);
            den   <= (EW+1)'(slow_env) + (EW+1)'(1);
            state <= DV_CHECK;
          end
        end
        DV_CHECK: begin
          // Quotient of 2^24 or more saturates
          if ((EW+9)'(num) >= den_sh) begin
            quo   <= '1;
            state <= DV_DONE;
          end else begin
            rem   <= num >> 8;
            nlo   <= {num[7:0], 16'h0000};
            cnt   <= '0;
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem <= fits ? (trial - den) : trial;
          quo <= {quo[RATIO_W-2:0], fits};
          nlo <= {nlo[RATIO_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(RATIO_W - 1)) begin
            state <= DV_DONE;
          end
        end
        DV_DONE: begin
          finished <= 1'b1;
          state    <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  assign res = '{done: finished, ratio: quo};

endmodule

FILE: rtl/tsh_delay.sv
// Circular delay memory with write pointer, fill count and tail addressing.
// Depends on tsh_pkg for the delay register width.
`timescale 1ns / 1ps

module tsh_delay import tsh_pkg::*; #(
  parameter int DELAY_DEPTH = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [DELAY_W-1:0]            delay_samples,
  output logic                          rd_ready,
  output logic signed [SAMPLE_BITS-1:0] rd_sample
);

  typedef enum logic [2:0] {DL_IDLE, DL_MOD, DL_TAIL, DL_READ, DL_DONE} dl_state_t;

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int FW = $clog2(DELAY_DEPTH + 1);
  localparam int CW = AW + DELAY_W + 1;
  localparam int TW = AW + 2;
  localparam int BW = $clog2(DELAY_W);

  dl_state_t                     state;
  logic [AW-1:0]                 wp;
  logic [FW-1:0]                 fill;
  logic [DELAY_W-1:0]            rem;
  logic [BW-1:0]                 bitpos;
  logic [AW-1:0]                 addr;
  logic                          rd_zero;
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic [CW-1:0]                 mod_sub;
  logic [TW-1:0]                 tail_raw;
  logic [TW-1:0]                 tail_wrap;

  // One reduction step of the delay modulo the depth, and the tail address
  always_comb begin
    mod_sub   = CW'(DELAY_DEPTH) << bitpos;
    tail_raw  = TW'(wp) + TW'(DELAY_DEPTH) - TW'(rem);
    tail_wrap = (tail_raw >= TW'(DELAY_DEPTH)) ? (tail_raw - TW'(DELAY_DEPTH)) : tail_raw;
  end

  // Store the sample and fetch the tail entry
  always_ff @(posedge clk) begin
    if (start) begin
      mem[wp] <= sample;
    end
    if (state == DL_READ) begin
      rd_q <= mem[addr];
    end
  end

  // Advance the pointer, then locate and read the delayed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DL_IDLE;
      wp       <= '0;
      fill     <= '0;
      rd_ready <= 1'b0;
    end else begin
      if (start) begin
        wp       <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : (wp + AW'(1));
        fill     <= (fill == FW'(DELAY_DEPTH)) ? fill : (fill + FW'(1));
        rem      <= delay_samples;
        bitpos   <= BW'(DELAY_W - 1);
        rd_ready <= 1'b0;
        state    <= DL_MOD;
      end else begin
        unique case (state)
          DL_IDLE: state <= DL_IDLE;
          DL_MOD: begin
            if (CW'(rem) >= mod_sub) begin
              rem <= rem - mod_sub[DELAY_W-1:0];
            end
            if (bitpos == '0) begin
              state <= DL_TAIL;
            end else begin
              bitpos <= bitpos - BW'(1);
            end
          end
          DL_TAIL: begin
            addr  <= tail_wrap[AW-1:0];
            state <= DL_READ;
          end
          DL_READ: begin
            // Entries at or above the fill count are still unwritten and read as zero
            rd_zero  <= !(FW'(addr) < fill);
            rd_ready <= 1'b1;
            state    <= DL_DONE;
          end
          DL_DONE: state <= DL_DONE;
          default: state <= DL_IDLE;
        endcase
      end
    end
  end

  assign rd_sample = rd_zero ? '0 : rd_q;

endmodule

FILE: rtl/transient_shaper.sv
// Transient shaper: each accepted sample is stored in a circular delay memory
// and drives a fast and a slow envelope follower; the ratio of the two sets a
// gain (attack emphasis above unity, sustain emphasis at or below), capped at
// 3.0, that scales the delayed sample, saturated to the sample width. From
// acceptance to its result, a sample waits on the 24-step ratio divider and
// goes through the single shared 17x33 multiplier, used in turn for both
// envelopes, the gain and the output product, and through the steps around it.
// The input is not ready while a sample is in work, but takes a new one while
// the previous result still waits in the output register. The delay memory
// needs no clearing pass: a fill count makes unwritten entries read as zero.
// Depends on tsh_pkg, tsh_if, tsh_mul, tsh_div and tsh_delay.
`timescale 1ns / 1ps

module transient_shaper import tsh_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tsh_in_if.sink     feed,
  tsh_out_if.source  result,
  tsh_cfg_if.sink    cfg
);

  localparam int EW = SAMPLE_BITS + 16;
  localparam int GW = 30;
  localparam int SB = SAMPLE_BITS;

  localparam logic signed [41:0] G_ONE = 42'sd268435456;
  localparam logic signed [41:0] G_CAP = 42'sd805306368;
  localparam logic signed [47:0] Y_MAX = 48'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [47:0] Y_MIN = -Y_MAX - 48'sd1;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_MHI, S_MLO, S_ACC, S_UPD, S_DIV, S_DIVW,
    S_SETUP, S_GMUL, S_G28, S_YHI, S_YLO, S_YACC, S_YSAT, S_OUT
  } state_t;

  // Configuration registers
  logic [COEFF_W-1:0] fast_coeff;
  logic [COEFF_W-1:0] slow_coeff;
  logic [COEFF_W-1:0] attack_amount;
  logic [COEFF_W-1:0] sustain_amount;
  logic [DELAY_W-1:0] delay_samples;

  // Sequencer state and datapath registers
  state_t                   state;
  logic [EW-1:0]            fast_env;
  logic [EW-1:0]            slow_env;
  logic [SB-1:0]            mag;
  logic                     sel_slow;
  logic                     up;
  logic [EW-1:0]            diff;
  logic [EW-1:0]            step;
  logic signed [MUL_P_W-1:0] p_first;
  logic [RATIO_W-1:0]       ratio;
  logic signed [24:0]       rdiff;
  logic signed [16:0]       adiff;
  logic signed [GW-1:0]     g16;
  logic signed [63:0]       yfull;
  logic signed [SB-1:0]     y;
  logic                     out_valid;
  logic signed [SB-1:0]     out_data;

  // Unit connections
  logic                      accept;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic                      div_start;
  div_res_t                  div_res;
  logic                      dly_ready;
  logic signed [SB-1:0]      dly_sample;

  // Combinational helpers
  logic [SB-1:0]         xin;
  logic [EW-1:0]         amag;
  logic [EW-1:0]         cur_env;
  logic [COEFF_W-1:0]    cur_k;
  logic [63:0]           diff_pad;
  logic [79:0]           env_sum;
  logic [EW-1:0]         env_new;
  logic signed [41:0]    g28;
  logic signed [63:0]    y_sum;
  logic signed [47:0]    y_shift;
  logic signed [SB-1:0]  y_sat;

  assign accept    = feed.valid && feed.ready;
  assign feed.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid      = out_valid;
  assign result.sample_out = out_data;
  assign div_start = (state == S_DIV);

  // Envelope step, gain and output arithmetic
  always_comb begin
    xin      = feed.sample_in;
    amag     = {mag, 16'h0000};
    cur_env  = sel_slow ? slow_env : fast_env;
    cur_k    = sel_slow ? slow_coeff : fast_coeff;
    diff_pad = 64'(diff);
    env_sum  = {p_first[47:0], 32'h0} + {32'h0, mul_prod[47:0]};
    env_new  = up ? (cur_env + step) : (cur_env - step);
    g28      = G_ONE + $signed(mul_prod[41:0]);
    if (g28 > G_CAP) begin
      g28 = G_CAP;
    end
    y_sum   = ($signed({{14{p_first[MUL_P_W-1]}}, p_first}) <<< 16)
            + $signed({{14{mul_prod[MUL_P_W-1]}}, mul_prod});
    y_shift = yfull[63:16];
    if (y_shift > Y_MAX) begin
      y_sat = Y_MAX[SB-1:0];
    end else if (y_shift < Y_MIN) begin
      y_sat = Y_MIN[SB-1:0];
    end else begin
      y_sat = y_shift[SB-1:0];
    end
  end

  // Route operands to the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MHI: begin
        mul_a = $signed({1'b0, cur_k});
        mul_b = $signed({1'b0, diff_pad[63:32]});
      end
      S_MLO: begin
        mul_a = $signed({1'b0, cur_k});
        mul_b = $signed({1'b0, diff_pad[31:0]});
      end
      S_GMUL: begin
        mul_a = adiff;
        mul_b = $signed({{8{rdiff[24]}}, rdiff});
      end
      S_YHI: begin
        mul_a = $signed({{3{g16[GW-1]}}, g16[GW-1:16]});
        mul_b = $signed({{(MUL_B_W-SB){dly_sample[SB-1]}}, dly_sample});
      end
      S_YLO: begin
        mul_a = $signed({1'b0, g16[15:0]});
        mul_b = $signed({{(MUL_B_W-SB){dly_sample[SB-1]}}, dly_sample});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Decode configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_coeff     <= FAST_COEFF_RST;
      slow_coeff     <= SLOW_COEFF_RST;
      attack_amount  <= ATTACK_AMOUNT_RST;
      sustain_amount <= SUSTAIN_AMOUNT_RST;
      delay_samples  <= DELAY_SAMPLES_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FAST_COEFF:     fast_coeff     <= cfg.data;
        REG_SLOW_COEFF:     slow_coeff     <= cfg.data;
        REG_ATTACK_AMOUNT:  attack_amount  <= cfg.data;
        REG_SUSTAIN_AMOUNT: sustain_amount <= cfg.data;
        REG_DELAY_SAMPLES:  delay_samples  <= cfg.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence one sample through envelopes, ratio, gain and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fast_env  <= '0;
      slow_env  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a delivered result unless the next one loads in the same cycle
      if (result.valid && result.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mag      <= xin[SB-1] ? SB'(~xin + SB'(1)) : xin;
            sel_slow <= 1'b0;
            state    <= S_DIFF;
          end
        end
        S_DIFF: begin
          up    <= (amag >= cur_env);
          diff  <= (amag >= cur_env) ? (amag - cur_env) : (cur_env - amag);
          state <= S_MHI;
        end
        S_MHI: state <= S_MLO;
        S_MLO: begin
          p_first <= mul_prod;
          state   <= S_ACC;
        end
        S_ACC: begin
          step  <= env_sum[16 +: EW];
          state <= S_UPD;
        end
        S_UPD: begin
          if (sel_slow) begin
            slow_env <= env_new;
            state    <= S_DIV;
          end else begin
            fast_env <= env_new;
            sel_slow <= 1'b1;
            state    <= S_DIFF;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_res.done) begin
            ratio <= div_res.ratio;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          // Attack above unity ratio, sustain at or below
          if (ratio > RATIO_W'(65536)) begin
            rdiff <= $signed({1'b0, ratio}) - 25'sd65536;
            adiff <= $signed({1'b0, attack_amount}) - 17'sd4096;
          end else begin
            rdiff <= 25'sd65536 - $signed({1'b0, ratio});
            adiff <= $signed({1'b0, sustain_amount}) - 17'sd4096;
          end
          state <= S_GMUL;
        end
        S_GMUL: state <= S_G28;
        S_G28: begin
          g16   <= g28[41:12];
          state <= S_YHI;
        end
        S_YHI: begin
          if (dly_ready) begin
            state <= S_YLO;
          end
        end
        S_YLO: begin
          p_first <= mul_prod;
          state   <= S_YACC;
        end
        S_YACC: begin
          yfull <= y_sum;
          state <= S_YSAT;
        end
        S_YSAT: begin
          y     <= y_sat;
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_data  <= y;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tsh_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  tsh_div #(
    .EW (EW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .fast_env (fast_env),
    .slow_env (slow_env),
    .res      (div_res)
  );

  tsh_delay #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_delay (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .sample        (feed.sample_in),
    .delay_samples (delay_samples),
    .rd_ready      (dly_ready),
    .rd_sample     (dly_sample)
  );

endmodule

FILE: rtl/tsh_checker.sv
// Port-level checks of the transient shaper, bound to the top level.
// Depends on tsh_pkg and on the transient_shaper ports.
`timescale 1ns / 1ps

module tsh_checker import tsh_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   feed_valid,
  input logic                   feed_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [SAMPLE_BITS-1:0] res_data
);

  logic [1:0] pending;
  logic       in_xact;
  logic       out_xact;

  assign in_xact  = feed_valid && feed_ready;
  assign out_xact = res_valid && res_ready;

  // Count samples accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_xact) - 2'(out_xact);
    end
  end

  // One sample in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xact |=> !feed_ready)
    else $error("input ready right after a transaction");

  // No result without an accepted sample
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_xact |-> (pending != 2'd0))
    else $error("result transaction without an accepted sample");

  // At most one sample in work plus one in the output register
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many samples outstanding");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed or dropped");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind transient_shaper tsh_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tsh_checker (
  .clk        (clk),
  .rst        (rst),
  .feed_valid (feed.valid),
  .feed_ready (feed.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.sample_out)
);

FILE: tb/tb_transient_shaper.sv
// Self-checking testbench for transient_shaper: drives samples and register writes,
// predicts every output sample and compares it with what the block returns.
// Depends on tsh_pkg, tsh_if and the transient_shaper RTL.
`timescale 1ns / 1ps

module tb_transient_shaper;
  import tsh_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int DEPTH       = DELAY_DEPTH_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int SETTLE      = 64;
  localparam int HOLD_OFF    = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_CAP   = 40;

  localparam longint UNITY_Q16   = 65536;
  localparam longint UNITY_Q28   = 64'sd1 <<< 28;
  localparam longint GAIN_CEIL   = 3 * UNITY_Q28;
  localparam longint NEUTRAL_Q12 = 4096;
  localparam longint RATIO_CEIL  = 64'h00FF_FFFF;
  localparam longint SAMPLE_MAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;

  typedef enum int {RAW_NOISE, PERCUSSIVE, QUIET} sample_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsh_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) feed_ch ();
  tsh_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();
  tsh_cfg_if cfg_ch ();

  transient_shaper dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shaper model: delay memory, envelopes and registers
  logic signed [SAMPLE_BITS-1:0] tail_mem [DEPTH];
  logic [DELAY_W-1:0]            wr_pos;
  longint                        env_fast, env_slow;
  logic [COEFF_W-1:0]            reg_fast, reg_slow, reg_attack, reg_sustain;
  logic [DELAY_W-1:0]            reg_delay;

  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  logic signed [SAMPLE_BITS-1:0] predicted_out [$];
  int  feeds_left   = 0;
  int  mismatches   = 0;
  int  stall_cycles = 0;
  bit  feed_fire, out_fire, cfg_fire;
  bit  feed_idles = 1'b0;
  bit  sink_idles = 1'b0;
  int  sink_hold_ask  = 0;
  int  sink_hold_left = 0;

  function automatic longint track_envelope(longint env, longint mag, longint k);
    if (mag >= env) return env + ((k * (mag - env)) >>> 16);
    return env - ((k * (env - mag)) >>> 16);
  endfunction

  // Advance the model by one sample and return the expected output
  function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(
      logic signed [SAMPLE_BITS-1:0] x);
    longint mag, ratio, gain28, gain16, delayed, y;
    logic [DELAY_W-1:0] tail;
    tail_mem[wr_pos] = x;
    wr_pos = wr_pos + 1'b1;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    mag = mag <<< 16;
    env_fast = track_envelope(env_fast, mag, longint'(reg_fast));
    env_slow = track_envelope(env_slow, mag, longint'(reg_slow));
    ratio = ((env_fast + 1) <<< 16) / (env_slow + 1);
    if (ratio > RATIO_CEIL) ratio = RATIO_CEIL;
    // Attack emphasis above unity ratio, sustain emphasis otherwise
    if (ratio > UNITY_Q16)
      gain28 = UNITY_Q28 + (ratio - UNITY_Q16) * (longint'(reg_attack) - NEUTRAL_Q12);
    else
      gain28 = UNITY_Q28 + (UNITY_Q16 - ratio) * (longint'(reg_sustain) - NEUTRAL_Q12);
    if (gain28 > GAIN_CEIL) gain28 = GAIN_CEIL;
    gain16 = gain28 >>> 12;
    tail = wr_pos - reg_delay;
    delayed = longint'(tail_mem[tail]);
    y = (delayed * gain16) >>> 16;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FAST_COEFF:     reg_fast    = val[COEFF_W-1:0];
      REG_SLOW_COEFF:     reg_slow    = val[COEFF_W-1:0];
      REG_ATTACK_AMOUNT:  reg_attack  = val[COEFF_W-1:0];
      REG_SUSTAIN_AMOUNT: reg_sustain = val[COEFF_W-1:0];
      REG_DELAY_SAMPLES:  reg_delay   = val[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Monitor: sample every handshake at the rising edge
  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    feed_fire = !rst && feed_ch.valid && feed_ch.ready;
    out_fire  = !rst && result_ch.valid && result_ch.ready;
    cfg_fire  = !rst && cfg_ch.valid && cfg_ch.ready;
    // Check the output transaction before queueing a new prediction
    if (out_fire) begin
      if (predicted_out.size() == 0) begin
        flag_mismatch($sformatf("sample_out %0d with nothing pending",
                                result_ch.sample_out));
      end else begin
        want = predicted_out.pop_front();
        if (result_ch.sample_out !== want)
          flag_mismatch($sformatf("sample_out got %0d want %0d",
                                  result_ch.sample_out, want));
      end
    end
    if (cfg_fire) apply_reg(cfg_ch.index, cfg_ch.data);
    if (feed_fire) begin
      predicted_out.push_back(shape_sample(feed_ch.sample_in));
      feeds_left--;
    end
    if (rst || feed_fire || out_fire || cfg_fire) stall_cycles = 0;
    else stall_cycles++;
  end

  // Sample driver: hold a transaction until taken, otherwise offer or idle
  always @(negedge clk) begin
    if (rst) begin
      feed_ch.valid <= 1'b0;
    end else if (!feed_ch.valid || feed_fire) begin
      if (pending_samples.size() != 0 && !(feed_idles && $urandom_range(99) < 25)) begin
        feed_ch.valid     <= 1'b1;
        feed_ch.sample_in <= pending_samples.pop_front();
      end else begin
        feed_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random backpressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (sink_hold_ask != 0) begin
      sink_hold_left = sink_hold_ask - 1;
      sink_hold_ask  = 0;
      result_ch.ready <= 1'b0;
    end else if (sink_hold_left != 0) begin
      sink_hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !(sink_idles && $urandom_range(99) < 25);
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_sample(logic signed [SAMPLE_BITS-1:0] smp);
    pending_samples.push_back(smp);
    feeds_left++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every sample is taken and every output has come back
  task automatic wait_drained();
    do @(negedge clk); while (feeds_left != 0 || predicted_out.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int pick_value(int top, int mid);
    case ($urandom_range(4))
      0:       return 0;
      1:       return top;
      2:       return mid;
      default: return $urandom_range(top);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_BITS-1:0] smp;
    int level;
    sample_style_t style;

    feed_ch.valid     = 1'b0;
    feed_ch.sample_in = '0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_FAST_COEFF;
    cfg_ch.data       = '0;
    foreach (tail_mem[i]) tail_mem[i] = '0;
    wr_pos      = '0;
    env_fast    = 0;
    env_slow    = 0;
    reg_fast    = FAST_COEFF_RST;
    reg_slow    = SLOW_COEFF_RST;
    reg_attack  = ATTACK_AMOUNT_RST;
    reg_sustain = SUSTAIN_AMOUNT_RST;
    reg_delay   = DELAY_SAMPLES_RST;
    level       = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Field extremes under the reset settings
    queue_sample('0);
    queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
    queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
    queue_sample(SAMPLE_BITS'(-1));
    queue_sample(SAMPLE_BITS'(1));
    queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
    queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
    queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
    wait_drained();

    // Unused indexes are ignored; upper delay bits are masked, leaving a delay of one
    for (int i = REG_DELAY_SAMPLES + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(cfg_idx_t'(i), CFG_DATA_W'($urandom));
    write_reg(REG_DELAY_SAMPLES, 16'hFC01);
    queue_sample(SAMPLE_BITS'(1234567));
    queue_sample(SAMPLE_BITS'(-7654321));
    queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
    queue_sample(SAMPLE_BITS'(-42));
    wait_drained();

    // Zero delay reads the oldest entry
    write_reg(REG_DELAY_SAMPLES, 16'd0);
    queue_sample(SAMPLE_BITS'(777));
    queue_sample(SAMPLE_BITS'(-555555));
    queue_sample(SAMPLE_BITS'(3));
    wait_drained();

    // Negative gain: no attack, instant fast envelope, frozen slow envelope
    write_reg(REG_FAST_COEFF, 16'hFFFF);
    write_reg(REG_SLOW_COEFF, 16'd0);
    write_reg(REG_ATTACK_AMOUNT, 16'd0);
    write_reg(REG_SUSTAIN_AMOUNT, 16'hFFFF);
    write_reg(REG_DELAY_SAMPLES, 16'd1);
    queue_sample('0);
    queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
    queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
    queue_sample(SAMPLE_BITS'(100));
    queue_sample('0);

    // Random phases, each starting from an idle block with fresh settings
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_reg(REG_FAST_COEFF, CFG_DATA_W'(pick_value(16'hFFFF, 9830)));
      write_reg(REG_SLOW_COEFF, CFG_DATA_W'(pick_value(16'hFFFF, 655)));
      write_reg(REG_ATTACK_AMOUNT, CFG_DATA_W'(pick_value(16'hFFFF, 4096)));
      write_reg(REG_SUSTAIN_AMOUNT, CFG_DATA_W'(pick_value(16'hFFFF, 4096)));
      write_reg(REG_DELAY_SAMPLES, CFG_DATA_W'(($urandom & 32'hFC00) |
                (ph == 0 ? DEPTH - 1 : pick_value(DEPTH - 1, 1))));
      if ($urandom_range(1))
        write_reg(cfg_idx_t'($urandom_range(2 ** CFG_IDX_W - 1, REG_DELAY_SAMPLES + 1)),
                  CFG_DATA_W'($urandom));

      // One phase runs with no idling on either side
      feed_idles = (ph != 1);
      sink_idles = (ph != 1);
      if (ph == 2) sink_hold_ask = HOLD_OFF;
      style = (ph % 4 == 0) ? RAW_NOISE : (ph % 4 == 3) ? QUIET : PERCUSSIVE;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case (style)
          RAW_NOISE: smp = SAMPLE_BITS'($urandom);
          PERCUSSIVE: begin
            // Sparse hits decaying into near silence, with some noise mixed in
            if ($urandom_range(40) == 0) level = $urandom_range(int'(SAMPLE_MAX));
            else level = level - level / 16;
            smp = SAMPLE_BITS'($urandom_range(level));
            if ($urandom_range(1)) smp = -smp;
            if ($urandom_range(9) == 0) smp = SAMPLE_BITS'($urandom);
          end
          default: smp = SAMPLE_BITS'(int'($urandom_range(511)) - 256);
        endcase
        queue_sample(smp);
      end
    end

    wait_drained();
    if (mismatches == 0 && predicted_out.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
